[design/led_matrix_number_pattern_core_defines.svh]
// ----------------------------------------------------------------------------
// led_matrix_number_pattern_core_defines
// Assertion macros shared by the number pattern core.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_NUMBER_PATTERN_CORE_DEFINES_SVH
`define LED_MATRIX_NUMBER_PATTERN_CORE_DEFINES_SVH

// Plain clocked check, off during reset.
`define LMNP_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Clocked implication, off during reset.
`define LMNP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[design/lmnp_pkg.sv]
// ----------------------------------------------------------------------------
// lmnp_pkg
// Constants and font tables for the LED matrix number pattern core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmnp_pkg;

   localparam int ValueWidth = 16;
   localparam int MagWidth   = 11;
   localparam int RestWidth  = 10;
   localparam int RemWidth   = 7;
   localparam int DigitWidth = 4;
   localparam int RowWidth   = 8;
   localparam int RowCount   = 8;

   localparam logic signed [ValueWidth-1:0] SatHigh = 16'sd1999;
   localparam logic signed [ValueWidth-1:0] SatLow  = -16'sd1999;
   localparam logic [MagWidth-1:0]          SatMag  = 11'd1999;
   localparam logic [MagWidth-1:0]          Thousand = 11'd1000;

   // rest * 41 >> 12 equals rest / 100 for rest below 1000
   localparam logic [5:0]  HundRecip = 6'd41;
   localparam int          HundShift = 12;
   // rem * 205 >> 11 equals rem / 10 for rem below 100
   localparam logic [7:0]  TensRecip = 8'd205;
   localparam int          TensShift = 11;

   typedef logic [DigitWidth-1:0] digit_type;
   typedef logic [RowWidth-1:0]   row_type;

   // Five font lines of three bits each, line 0 in the lowest bits.
   function automatic logic [14:0] digit_font(input digit_type d);
      logic [14:0] f;
      unique case (d)
         4'd0:    f = {3'h7, 3'h5, 3'h5, 3'h5, 3'h7};
         4'd1:    f = {3'h4, 3'h4, 3'h4, 3'h4, 3'h4};
         4'd2:    f = {3'h7, 3'h1, 3'h7, 3'h4, 3'h7};
         4'd3:    f = {3'h7, 3'h4, 3'h7, 3'h4, 3'h7};
         4'd4:    f = {3'h4, 3'h4, 3'h7, 3'h5, 3'h5};
         4'd5:    f = {3'h7, 3'h4, 3'h7, 3'h1, 3'h7};
         4'd6:    f = {3'h7, 3'h5, 3'h7, 3'h1, 3'h7};
         4'd7:    f = {3'h4, 3'h4, 3'h4, 3'h4, 3'h7};
         4'd8:    f = {3'h7, 3'h5, 3'h7, 3'h5, 3'h7};
         4'd9:    f = {3'h7, 3'h4, 3'h7, 3'h5, 3'h7};
         default: f = '0;
      endcase
      return f;
   endfunction

   // Bar graph bytes, row 6 in the low byte and row 7 in the high byte.
   function automatic logic [15:0] bar_rows(input digit_type d);
      logic [15:0] b;
      unique case (d)
         4'd0:    b = {8'h00, 8'h00};
         4'd1:    b = {8'h40, 8'h00};
         4'd2:    b = {8'h60, 8'h40};
         4'd3:    b = {8'h70, 8'h60};
         4'd4:    b = {8'h78, 8'h70};
         4'd5:    b = {8'h7c, 8'h78};
         4'd6:    b = {8'h7e, 8'h7c};
         4'd7:    b = {8'h7f, 8'h7e};
         4'd8:    b = {8'hff, 8'h7f};
         4'd9:    b = {8'hff, 8'hff};
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

[design/led_matrix_number_pattern_core.sv]
// ----------------------------------------------------------------------------
// led_matrix_number_pattern_core
// Turns a signed number into the eight row bytes of an 8x8 LED matrix image.
// ----------------------------------------------------------------------------
// The core takes one number per clock when not stalled and returns its
// image through a five-stage pipeline: saturate to +/-1999, strip the
// thousands, split off the hundreds digit, split tens and units, then
// look up the font and bar graph into the output register. Each stage
// holds its item while the stage after it is full and stalled, so
// backpressure on rsp_tready ripples back to req_tready in the same cycle
// and the pipeline still accepts an item whenever any stage has room.
`timescale 1ns / 1ps
`default_nettype none

`include "led_matrix_number_pattern_core_defines.svh"

module led_matrix_number_pattern_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // value [15:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // row0 [7:0] up to row7 [63:56]
);

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: sign and saturated magnitude
   logic                                 neg1_ff,  neg1_in;
   logic [lmnp_pkg::MagWidth-1:0]        mag1_ff,  mag1_in;
   // stage 2: thousands flag and remainder below 1000
   logic                                 neg2_ff;
   logic                                 thou2_ff, thou2_in;
   logic [lmnp_pkg::RestWidth-1:0]       rest2_ff, rest2_in;
   // stage 3: hundreds digit and remainder below 100
   logic                                 neg3_ff, thou3_ff;
   lmnp_pkg::digit_type                  hund3_ff, hund3_in;
   logic [lmnp_pkg::RemWidth-1:0]        rem3_ff,  rem3_in;
   // stage 4: tens and units
   logic                                 neg4_ff, thou4_ff;
   lmnp_pkg::digit_type                  hund4_ff;
   lmnp_pkg::digit_type                  tens4_ff, tens4_in;
   lmnp_pkg::digit_type                  unit4_ff, unit4_in;
   // stage 5: output image
   logic [63:0]                          img5_ff,  img5_in;

   logic signed [lmnp_pkg::ValueWidth-1:0] value;
   logic signed [lmnp_pkg::ValueWidth-1:0] value_neg;
   logic [15:0]                          hund_prod;
   logic [14:0]                          tens_prod;
   logic [14:0]                          hfont, tfont;
   logic [15:0]                          bars;

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_tready = rdy1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = img5_ff;

   always_comb begin
      value     = signed'(req_tdata);
      value_neg = -value;
      neg1_in   = value[lmnp_pkg::ValueWidth-1];
      if (value > lmnp_pkg::SatHigh) begin
         mag1_in = lmnp_pkg::SatMag;
      end else if (value < lmnp_pkg::SatLow) begin
         mag1_in = lmnp_pkg::SatMag;
      end else if (neg1_in) begin
         mag1_in = value_neg[lmnp_pkg::MagWidth-1:0];
      end else begin
         mag1_in = value[lmnp_pkg::MagWidth-1:0];
      end
   end

   always_comb begin
      thou2_in = mag1_ff >= lmnp_pkg::Thousand;
      if (thou2_in) begin
         rest2_in = lmnp_pkg::RestWidth'(mag1_ff - lmnp_pkg::Thousand);
      end else begin
         rest2_in = mag1_ff[lmnp_pkg::RestWidth-1:0];
      end
   end

   always_comb begin
      hund_prod = 16'(rest2_ff) * 16'(lmnp_pkg::HundRecip);
      hund3_in  = hund_prod[lmnp_pkg::HundShift +: lmnp_pkg::DigitWidth];
      rem3_in   = lmnp_pkg::RemWidth'(rest2_ff - 10'(hund3_in) * 10'd100);
   end

   always_comb begin
      tens_prod = 15'(rem3_ff) * 15'(lmnp_pkg::TensRecip);
      tens4_in  = tens_prod[lmnp_pkg::TensShift +: lmnp_pkg::DigitWidth];
      unit4_in  = lmnp_pkg::DigitWidth'(rem3_ff - 7'(tens4_in) * 7'd10);
   end

   always_comb begin
      hfont   = lmnp_pkg::digit_font(hund4_ff);
      tfont   = lmnp_pkg::digit_font(tens4_ff);
      bars    = lmnp_pkg::bar_rows(unit4_ff);
      img5_in = {bars,
                 {thou4_ff, 7'h00},
                 {1'b0, tfont[14:12], 1'b0, hfont[14:12]},
                 {1'b0, tfont[11:9],  1'b0, hfont[11:9]},
                 {neg4_ff, tfont[8:6], 1'b0, hfont[8:6]},
                 {1'b0, tfont[5:3],   1'b0, hfont[5:3]},
                 {1'b0, tfont[2:0],   1'b0, hfont[2:0]}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // payload advances with its stage, no reset
   always_ff @(posedge clock) begin
      if (rdy1) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (rdy2) begin
         neg2_ff  <= neg1_ff;
         thou2_ff <= thou2_in;
         rest2_ff <= rest2_in;
      end
      if (rdy3) begin
         neg3_ff  <= neg2_ff;
         thou3_ff <= thou2_ff;
         hund3_ff <= hund3_in;
         rem3_ff  <= rem3_in;
      end
      if (rdy4) begin
         neg4_ff  <= neg3_ff;
         thou4_ff <= thou3_ff;
         hund4_ff <= hund3_ff;
         tens4_ff <= tens4_in;
         unit4_ff <= unit4_in;
      end
      if (rdy5) begin
         img5_ff <= img5_in;
      end
   end

   `LMNP_ASSERT_IMPL(a_mag_sat, v1_ff, mag1_ff <= lmnp_pkg::SatMag, "magnitude above limit")
   `LMNP_ASSERT_IMPL(a_hund_rng, v3_ff, hund3_ff <= 4'd9 && rem3_ff <= 7'd99, "bad hundreds split")
   `LMNP_ASSERT_IMPL(a_tens_rng, v4_ff, tens4_ff <= 4'd9 && unit4_ff <= 4'd9, "bad tens split")
   `LMNP_ASSERT(a_empty_ready, v5_ff || req_tready, "empty output stage but input stalled")

endmodule

`default_nettype wire
